// ----- hw/rtl/jsrr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the jog step-rate ramp: widths, constants, codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package jsrr_pkg;

  // Field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SW_W     = 6;
  localparam int unsigned XPOS_W   = 32;   // position fields on the channels
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned SKIP_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Parameter defaults
  localparam int unsigned POS_BITS_DEF = 32;
  localparam int unsigned AXES_DEF     = 3;

  // Timer period numerator and the divider built around it
  localparam int unsigned PERIOD_NUM = 1710000;
  localparam int unsigned NUM_BITS   = $clog2(PERIOD_NUM + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(NUM_BITS);
  localparam logic [NUM_BITS-1:0] PERIOD_NUM_V = NUM_BITS'(PERIOD_NUM);

  // Ramp constants
  localparam logic [RATE_W:0]   DEAD_BAND  = (RATE_W+1)'(5);
  localparam logic [RATE_W-1:0] BRAKE_STEP = RATE_W'(10);

  // Switch masks: Z switches, Y switches, reverse switches
  localparam logic [SW_W-1:0] SW_Z_MASK   = 6'h24;
  localparam logic [SW_W-1:0] SW_Y_MASK   = 6'h12;
  localparam logic [SW_W-1:0] SW_REV_MASK = 6'h38;

  // Register reset values
  localparam logic [RATE_W-1:0] MIN_RATE_RST    = RATE_W'(100);
  localparam logic [STEP_W-1:0] RAMP_STEP_RST   = STEP_W'(1);
  localparam logic [RATE_W-1:0] TARGET_RATE_RST = RATE_W'(4000);
  localparam logic [SKIP_W-1:0] SKIP_RELOAD_RST = SKIP_W'(8);
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(PERIOD_NUM / 100);

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_TIMER = 2'd1,
    FUNC_ABORT = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RATE    = 2'd0,
    CFG_RAMP_STEP   = 2'd1,
    CFG_TARGET_RATE = 2'd2,
    CFG_SKIP_RELOAD = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUSH = 4'b1000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take the request payload
    logic exec;       // apply the request to the jog state
    logic div_start;  // recompute the timer period
    logic load_out;   // load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;   // the request changes the rate
    logic div_done;   // period is ready
  } dp_status_t;

endpackage

// ----- hw/rtl/jsrr_in_if.sv -----
`timescale 1ns / 1ps
// Request channel of the jog step-rate ramp: valid/ready plus the request fields.
// Depends on jsrr_pkg.
interface jsrr_in_if
  import jsrr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [SW_W-1:0]          switches;
  logic                     limit_active;
  logic signed [XPOS_W-1:0] start_position;

  modport source (output valid, func, switches, limit_active, start_position,
                  input ready);
  modport sink   (input valid, func, switches, limit_active, start_position,
                  output ready);
endinterface

// ----- hw/rtl/jsrr_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the jog step-rate ramp: valid/ready plus the result fields.
// Depends on jsrr_pkg.
interface jsrr_out_if
  import jsrr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     step_pulse;
  logic [AXIS_W-1:0]        axis;
  logic                     direction;
  logic signed [XPOS_W-1:0] position;
  logic [PERIOD_W-1:0]      timer_period;
  logic                     active;
  logic [RATE_W-1:0]        current_rate;

  modport source (output valid, step_pulse, axis, direction, position, timer_period,
                         active, current_rate,
                  input ready);
  modport sink   (input valid, step_pulse, axis, direction, position, timer_period,
                        active, current_rate,
                  output ready);
endinterface

// ----- hw/rtl/jsrr_div.sv -----
`timescale 1ns / 1ps
// Restoring divider: fixed numerator over the step rate, one quotient bit per
// cycle, result saturated to the timer width. Depends on jsrr_pkg.
module jsrr_div
  import jsrr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RATE_W-1:0]   divisor_i,
  output logic                done_o,
  output logic [PERIOD_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RATE_W-1:0]    rem_q, rem_d;
  logic [NUM_BITS-1:0]  quo_q, quo_d;

  logic [RATE_W:0]      rem_sh;
  logic [RATE_W:0]      rem_sub;
  logic                 ge;

  // One restoring step: shift in the next numerator bit, trial subtract
  always_comb begin
    rem_sh  = {rem_q, PERIOD_NUM_V[cnt_q]};
    rem_sub = rem_sh - {1'b0, divisor_i};
    ge      = (rem_sh >= {1'b0, divisor_i});
  end

  // Sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(NUM_BITS - 1);
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops out
      rem_d = ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      quo_d = {quo_q[NUM_BITS-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // A zero divisor yields all ones and so saturates as well
  assign done_o     = done_q;
  assign quotient_o = (|quo_q[NUM_BITS-1:PERIOD_W]) ? '1 : quo_q[PERIOD_W-1:0];

endmodule

// ----- hw/rtl/jsrr_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the jog step-rate ramp: configuration registers, jog state,
// rate ramp, position counter, period divider and result register.
// Depends on jsrr_pkg and jsrr_div.
module jsrr_datapath
  import jsrr_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF,
  parameter int unsigned AXES     = AXES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  // request payload
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [SW_W-1:0]          switches_i,
  input  logic                     limit_active_i,
  input  logic signed [XPOS_W-1:0] start_position_i,
  // control
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               status_o,
  // result payload
  output logic                     step_pulse_o,
  output logic [AXIS_W-1:0]        axis_o,
  output logic                     direction_o,
  output logic signed [XPOS_W-1:0] position_o,
  output logic [PERIOD_W-1:0]      timer_period_o,
  output logic                     active_o,
  output logic [RATE_W-1:0]        current_rate_o
);

  // Configuration registers
  logic [RATE_W-1:0] min_rate_q;
  logic [STEP_W-1:0] ramp_step_q;
  logic [RATE_W-1:0] target_rate_q;
  logic [SKIP_W-1:0] skip_reload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q    <= MIN_RATE_RST;
      ramp_step_q   <= RAMP_STEP_RST;
      target_rate_q <= TARGET_RATE_RST;
      skip_reload_q <= SKIP_RELOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_RATE:    min_rate_q    <= cfg_wdata_i[RATE_W-1:0];
        CFG_RAMP_STEP:   ramp_step_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_TARGET_RATE: target_rate_q <= cfg_wdata_i[RATE_W-1:0];
        CFG_SKIP_RELOAD: skip_reload_q <= cfg_wdata_i[SKIP_W-1:0];
        default:         ;
      endcase
    end
  end

  // Captured request
  func_e                    func_q;
  logic [SW_W-1:0]          sw_q;
  logic                     limit_q;
  logic signed [XPOS_W-1:0] start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_e'(func_i);
      sw_q    <= switches_i;
      limit_q <= limit_active_i;
      start_q <= start_position_i;
    end
  end

  // Jog state
  logic                running_q, running_d;
  logic [SW_W-1:0]     latched_q, latched_d;
  logic [AXIS_W-1:0]   axis_q, axis_d;
  logic                reverse_q, reverse_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [SKIP_W-1:0]   skip_q, skip_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                pulse_q, pulse_d;
  logic [PERIOD_W-1:0] period_q;

  // Ramp toward the target with a dead band, and the brake step
  logic [RATE_W:0]   rate_up;
  logic [RATE_W-1:0] rate_r1;
  logic [RATE_W-1:0] rate_ramp;
  logic [RATE_W-1:0] rate_brake;
  logic [AXIS_W-1:0] axis_dec;
  logic              div_done;
  logic [PERIOD_W-1:0] div_quo;

  always_comb begin
    rate_up = {1'b0, rate_q} + {{(RATE_W+1-STEP_W){1'b0}}, ramp_step_q};
    if (({1'b0, rate_q} + DEAD_BAND) < {1'b0, target_rate_q}) begin
      rate_r1 = rate_up[RATE_W] ? '1 : rate_up[RATE_W-1:0];
    end else begin
      rate_r1 = rate_q;
    end
    if ({1'b0, rate_r1} > ({1'b0, target_rate_q} + DEAD_BAND)) begin
      rate_ramp = (rate_r1 > RATE_W'(ramp_step_q)) ? rate_r1 - RATE_W'(ramp_step_q) : '0;
    end else begin
      rate_ramp = rate_r1;
    end
    rate_brake = (rate_q > BRAKE_STEP) ? rate_q - BRAKE_STEP : '0;
  end

  // Axis from the switches: Z beats Y beats X, clipped to the axes present
  always_comb begin
    if (|(sw_q & SW_Z_MASK)) begin
      axis_dec = AXIS_Z;
    end else if (|(sw_q & SW_Y_MASK)) begin
      axis_dec = AXIS_Y;
    end else begin
      axis_dec = AXIS_X;
    end
    if (axis_dec >= AXIS_W'(AXES)) begin
      axis_dec = AXIS_W'(AXES - 1);
    end
  end

  // Request execution
  always_comb begin
    running_d = running_q;
    latched_d = latched_q;
    axis_d    = axis_q;
    reverse_d = reverse_q;
    rate_d    = rate_q;
    skip_d    = skip_q;
    pos_d     = pos_q;
    pulse_d   = 1'b0;
    unique case (func_q)
      FUNC_START: begin
        if (sw_q != '0) begin
          axis_d    = axis_dec;
          reverse_d = |(sw_q & SW_REV_MASK);
          latched_d = sw_q;
          pos_d     = POS_BITS'(start_q);
          rate_d    = min_rate_q;
          skip_d    = '0;
          running_d = 1'b1;
        end
      end
      FUNC_TIMER: begin
        if (running_q) begin
          if (skip_q == '0) begin
            if (limit_q && reverse_q) begin
              running_d = 1'b0;
            end
            if (sw_q == latched_q) begin
              rate_d = rate_ramp;
            end else if (rate_q > min_rate_q) begin
              rate_d = rate_brake;
            end else begin
              running_d = 1'b0;
            end
            pulse_d = 1'b1;
            pos_d   = reverse_q ? pos_q - POS_BITS'(1) : pos_q + POS_BITS'(1);
            skip_d  = skip_reload_q;
          end else begin
            skip_d = skip_q - SKIP_W'(1);
          end
        end
      end
      FUNC_ABORT: running_d = 1'b0;
      FUNC_NOP:   ;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      latched_q <= '0;
      axis_q    <= AXIS_X;
      reverse_q <= 1'b0;
      rate_q    <= MIN_RATE_RST;
      skip_q    <= '0;
      pos_q     <= '0;
      pulse_q   <= 1'b0;
      period_q  <= PERIOD_RST;
    end else begin
      if (cmd_i.exec) begin
        running_q <= running_d;
        latched_q <= latched_d;
        axis_q    <= axis_d;
        reverse_q <= reverse_d;
        rate_q    <= rate_d;
        skip_q    <= skip_d;
        pos_q     <= pos_d;
        pulse_q   <= pulse_d;
      end
      if (div_done) begin
        period_q <= div_quo;
      end
    end
  end

  // Period divider, run on the stored rate
  jsrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .divisor_i  (rate_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign status_o.need_div = (rate_d != rate_q);
  assign status_o.div_done = div_done;

  // Result register
  logic                     o_pulse_q;
  logic [AXIS_W-1:0]        o_axis_q;
  logic                     o_dir_q;
  logic signed [XPOS_W-1:0] o_pos_q;
  logic [PERIOD_W-1:0]      o_period_q;
  logic                     o_active_q;
  logic [RATE_W-1:0]        o_rate_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_pulse_q  <= pulse_q;
      o_axis_q   <= axis_q;
      o_dir_q    <= reverse_q;
      o_pos_q    <= XPOS_W'(pos_q);
      o_period_q <= period_q;
      o_active_q <= running_q;
      o_rate_q   <= rate_q;
    end
  end

  assign step_pulse_o   = o_pulse_q;
  assign axis_o         = o_axis_q;
  assign direction_o    = o_dir_q;
  assign position_o     = o_pos_q;
  assign timer_period_o = o_period_q;
  assign active_o       = o_active_q;
  assign current_rate_o = o_rate_q;

endmodule

// ----- hw/rtl/jsrr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the jog step-rate ramp: sequences capture, execution, the
// period division and the result register handshake. Depends on jsrr_pkg.
module jsrr_ctrl
  import jsrr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/jog_step_rate_ramp.sv -----
`timescale 1ns / 1ps
// Top level of the jog step-rate ramp: controller plus datapath.
// Depends on jsrr_pkg, jsrr_in_if, jsrr_out_if, jsrr_ctrl, jsrr_datapath.
//
//   channel  dir  handshake         carries
//   in_i     in   valid/ready       func, switches, limit_active, start_position
//   out_o    out  valid/ready       step_pulse, axis, direction, position,
//                                   timer_period, active, current_rate
//   cfg      in   cfg_we_i          cfg_idx_i, cfg_wdata_i (write only)
//
// One request at a time. A request that changes the rate also runs the
// restoring divider (21 quotient bits, one per cycle) for the period; one that
// leaves the rate unchanged goes straight on to the result register.
// Reset is asynchronous and takes effect at once; no clearing pass.
// A new request is taken while the previous result waits in the output
// register; a stalled result only holds the next one back at its output load.
module jog_step_rate_ramp
  import jsrr_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEF,
  parameter int unsigned AXES     = AXES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jsrr_in_if.sink               in_i,
  jsrr_out_if.source            out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  jsrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Jog state, ramp and period
  jsrr_datapath #(
    .POS_BITS (POS_BITS),
    .AXES     (AXES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (in_i.func),
    .switches_i       (in_i.switches),
    .limit_active_i   (in_i.limit_active),
    .start_position_i (in_i.start_position),
    .cmd_i            (cmd),
    .status_o         (status),
    .step_pulse_o     (out_o.step_pulse),
    .axis_o           (out_o.axis),
    .direction_o      (out_o.direction),
    .position_o       (out_o.position),
    .timer_period_o   (out_o.timer_period),
    .active_o         (out_o.active),
    .current_rate_o   (out_o.current_rate)
  );

endmodule

// ----- tb/jog_step_rate_ramp_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the jog step-rate ramp: watches the request, result and register
// channels, predicts every result and compares it field by field.
// Depends on jsrr_pkg, jsrr_in_if and jsrr_out_if; assumes default POS_BITS and AXES.
module jog_step_rate_ramp_checker
  import jsrr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jsrr_in_if                    in_mon,
  jsrr_out_if                   out_mon,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  typedef struct packed {
    logic                     step_pulse;
    logic [AXIS_W-1:0]        axis;
    logic                     direction;
    logic signed [XPOS_W-1:0] position;
    logic [PERIOD_W-1:0]      timer_period;
    logic                     active;
    logic [RATE_W-1:0]        current_rate;
  } jog_status_t;

  // Register copies
  logic [RATE_W-1:0] min_rate;
  logic [STEP_W-1:0] ramp_step;
  logic [RATE_W-1:0] target_rate;
  logic [SKIP_W-1:0] skip_reload;

  // Jog state
  logic              running;
  logic [SW_W-1:0]   held_sw;
  logic [AXIS_W-1:0] axis_sel;
  logic              reversing;
  logic [RATE_W-1:0] rate_now;
  logic [SKIP_W-1:0] skip_left;
  logic [XPOS_W-1:0] pos_count;

  jog_status_t status_q[$];
  jog_status_t want;

  // Timer compare value for a rate; zero rate or a slow one saturates
  function automatic logic [PERIOD_W-1:0] period_for(input logic [RATE_W-1:0] rate);
    int unsigned q;
    if (rate == '0) return '1;
    q = PERIOD_NUM / rate;
    return (q > 65535) ? '1 : q[PERIOD_W-1:0];
  endfunction

  // Apply one request to the jog state and return the status it leaves
  function automatic jog_status_t next_status(input func_e f, input logic [SW_W-1:0] sw,
                                              input logic lim,
                                              input logic [XPOS_W-1:0] start);
    jog_status_t s;
    logic pulse;
    int r;
    int t;
    pulse = 1'b0;
    case (f)
      FUNC_START: begin
        // no switch pressed: nothing happens
        if (sw != '0) begin
          if (|(sw & SW_Z_MASK)) axis_sel = AXIS_Z;
          else if (|(sw & SW_Y_MASK)) axis_sel = AXIS_Y;
          else axis_sel = AXIS_X;
          reversing = |(sw & SW_REV_MASK);
          held_sw   = sw;
          pos_count = start;
          rate_now  = min_rate;
          skip_left = '0;
          running   = 1'b1;
        end
      end
      FUNC_TIMER: begin
        if (running) begin
          if (skip_left == '0) begin
            // limit while reversing stops, but this step still goes out
            if (lim && reversing) running = 1'b0;
            r = int'(rate_now);
            t = int'(target_rate);
            if (sw == held_sw) begin
              if (r < t - int'(DEAD_BAND))
                r = (r + int'(ramp_step) > 65535) ? 65535 : r + int'(ramp_step);
              if (r > t + int'(DEAD_BAND))
                r = (r > int'(ramp_step)) ? r - int'(ramp_step) : 0;
            end else if (r > int'(min_rate)) begin
              r = (r > int'(BRAKE_STEP)) ? r - int'(BRAKE_STEP) : 0;
            end else begin
              running = 1'b0;
            end
            rate_now  = r[RATE_W-1:0];
            pulse     = 1'b1;
            pos_count = reversing ? pos_count - 1'b1 : pos_count + 1'b1;
            skip_left = skip_reload;
          end else begin
            skip_left = skip_left - 1'b1;
          end
        end
      end
      FUNC_ABORT: running = 1'b0;
      default: ;
    endcase
    s.step_pulse   = pulse;
    s.axis         = axis_sel;
    s.direction    = reversing;
    s.position     = pos_count;
    s.timer_period = period_for(rate_now);
    s.active       = running;
    s.current_rate = rate_now;
    return s;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block's own updates land
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      min_rate     = MIN_RATE_RST;
      ramp_step    = RAMP_STEP_RST;
      target_rate  = TARGET_RATE_RST;
      skip_reload  = SKIP_RELOAD_RST;
      running      = 1'b0;
      held_sw      = '0;
      axis_sel     = AXIS_X;
      reversing    = 1'b0;
      rate_now     = MIN_RATE_RST;
      skip_left    = '0;
      pos_count    = '0;
      fail_count_o = 0;
      status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_RATE:    min_rate    = cfg_wdata_i[RATE_W-1:0];
          CFG_RAMP_STEP:   ramp_step   = cfg_wdata_i[STEP_W-1:0];
          CFG_TARGET_RATE: target_rate = cfg_wdata_i[RATE_W-1:0];
          CFG_SKIP_RELOAD: skip_reload = cfg_wdata_i[SKIP_W-1:0];
          default: ;
        endcase
      end
      // result side first: a result never belongs to a request of the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (status_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("step_pulse", want.step_pulse, out_mon.step_pulse);
          check_field("axis", want.axis, out_mon.axis);
          check_field("direction", want.direction, out_mon.direction);
          check_field("position", want.position, out_mon.position);
          check_field("timer_period", want.timer_period, out_mon.timer_period);
          check_field("active", want.active, out_mon.active);
          check_field("current_rate", want.current_rate, out_mon.current_rate);
        end
      end
      if (in_mon.valid && in_mon.ready)
        status_q.push_back(next_status(func_e'(in_mon.func), in_mon.switches,
                                       in_mon.limit_active, in_mon.start_position));
    end
    outstanding_o = status_q.size();
  end

endmodule

// ----- tb/jog_step_rate_ramp_tb.sv -----
`timescale 1ns / 1ps
// Top of the jog step-rate ramp bench: clock, reset, register writes, requests
// and result back-pressure; the scoreboard module does the checking.
// Depends on jsrr_pkg, the two channel interfaces, jog_step_rate_ramp and its checker.
module jog_step_rate_ramp_tb
  import jsrr_pkg::*;
;

  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no handshake at all
  localparam int unsigned SETTLE_CYCLES = 30;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int          fail_count;
  int          outstanding;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned jog_items;
  int unsigned cur_skip;
  int unsigned quiet_cycles;

  jsrr_in_if  in_ch ();
  jsrr_out_if out_ch ();

  jog_step_rate_ramp u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  jog_step_rate_ramp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: no request or result moving for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("jog_step_rate_ramp_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Offer one request, with random sender gaps, and hold it until taken
  task automatic send_request(input func_e f, input logic [SW_W-1:0] sw, input logic lim,
                              input logic [XPOS_W-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.func           <= f;
    in_ch.switches       <= sw;
    in_ch.limit_active   <= lim;
    in_ch.start_position <= pos;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // One jog: a start, then timer events, maybe a switch change (braking),
  // a limit, an abort or stray requests mixed in
  task automatic run_jog(input int unsigned room);
    logic [SW_W-1:0]   held;
    logic [SW_W-1:0]   sw_now;
    logic [XPOS_W-1:0] pos;
    int unsigned       n;
    int unsigned       brake_at;
    int unsigned       i;
    held = SW_W'($urandom_range(1, 63));
    pos  = $urandom;
    case ($urandom_range(3))
      0: pos = 32'h7FFF_FFFF - $urandom_range(3);
      1: pos = 32'h8000_0000 + $urandom_range(3);
      default: ;
    endcase
    send_request(FUNC_START, held, 1'($urandom_range(1)), pos);
    jog_items++;
    n = $urandom_range(1, 40 * (cur_skip + 1));
    if (n > 300) n = 300;
    if (n + 1 > room) n = (room > 1) ? room - 1 : 1;
    brake_at = ($urandom_range(99) < 35) ? $urandom_range(0, n) : n + 1;
    sw_now = held;
    for (i = 0; i < n; i++) begin
      if (i == brake_at)
        do sw_now = SW_W'($urandom_range(63)); while (sw_now == held);
      if ($urandom_range(99) < 3)
        send_request(FUNC_ABORT, SW_W'($urandom_range(63)), 1'($urandom_range(1)), $urandom);
      else
        send_request(FUNC_TIMER, sw_now, ($urandom_range(99) < 4), $urandom);
      jog_items++;
      if ($urandom_range(99) < 5)
        send_request(func_e'($urandom_range(3)), SW_W'($urandom_range(63)),
                     1'($urandom_range(1)), $urandom);
    end
  endtask

  initial begin
    int unsigned min_v;
    int unsigned ramp_v;
    int unsigned target_v;
    int unsigned budget;
    int          s;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_MIN_RATE;
    cfg_wdata_i          = '0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_NOP;
    in_ch.switches       = '0;
    in_ch.limit_active   = 1'b0;
    in_ch.start_position = '0;
    out_ch.ready         = 1'b0;
    quiet_cycles         = 0;
    tx_idle_pct          = 28;
    rx_idle_pct          = 71;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fast ramp, no skipped events
    cur_skip = 0;
    write_reg(CFG_MIN_RATE, 16'd10);
    write_reg(CFG_RAMP_STEP, 16'd255);
    write_reg(CFG_TARGET_RATE, 16'd65535);
    write_reg(CFG_SKIP_RELOAD, 16'd0);
    send_request(FUNC_NOP, 6'h3F, 1'b1, 32'hFFFF_FFFF);
    send_request(FUNC_TIMER, 6'h01, 1'b0, 32'h0);        // idle: ignored
    send_request(FUNC_ABORT, 6'h00, 1'b0, 32'h0);
    send_request(FUNC_START, 6'h00, 1'b0, 32'h1234);     // no switch: ignored
    send_request(FUNC_START, 6'h01, 1'b0, 32'h7FFF_FFFF);
    send_request(FUNC_TIMER, 6'h01, 1'b0, 32'h0);        // position wraps up
    send_request(FUNC_TIMER, 6'h01, 1'b1, 32'h0);        // limit going forward
    send_request(FUNC_START, 6'h08, 1'b0, 32'h8000_0000); // restart while running
    send_request(FUNC_TIMER, 6'h08, 1'b0, 32'h0);        // position wraps down
    send_request(FUNC_TIMER, 6'h08, 1'b1, 32'h0);        // limit while reversing
    send_request(FUNC_TIMER, 6'h08, 1'b0, 32'h0);
    send_request(FUNC_START, 6'h02, 1'b0, 32'h0);
    send_request(FUNC_TIMER, 6'h02, 1'b0, 32'h0);
    send_request(FUNC_TIMER, 6'h00, 1'b0, 32'h0);        // switches released: brake
    send_request(FUNC_START, 6'h10, 1'b0, 32'hFFFF_FFFF);
    send_request(FUNC_TIMER, 6'h3F, 1'b0, 32'h0);        // changed at min rate: stop
    send_request(FUNC_START, 6'h04, 1'b1, 32'd12345);
    send_request(FUNC_TIMER, 6'h04, 1'b0, 32'h0);
    send_request(FUNC_ABORT, 6'h04, 1'b0, 32'h0);
    send_request(FUNC_START, 6'h20, 1'b0, 32'h0);
    send_request(FUNC_TIMER, 6'h20, 1'b0, 32'h0);
    send_request(FUNC_START, 6'h3F, 1'b0, 32'h8000_0000);
    send_request(FUNC_TIMER, 6'h3F, 1'b1, 32'h0);
    send_request(FUNC_START, 6'h09, 1'b0, 32'h5555_AAAA);
    send_request(FUNC_TIMER, 6'h09, 1'b0, 32'hAAAA_5555);
    drain();

    // Random jogs over a range of register settings
    for (s = 0; s < 7; s++) begin
      case (s)
        0: begin min_v = 100;   ramp_v = 1;   target_v = 4000;  cur_skip = 8;   budget = 150; end
        1: begin min_v = 1;     ramp_v = 255; target_v = 65535; cur_skip = 0;   budget = 200; end
        2: begin min_v = 65535; ramp_v = 255; target_v = 1;     cur_skip = 0;   budget = 150; end
        3: begin min_v = 200;   ramp_v = 255; target_v = 1;     cur_skip = 1;   budget = 200; end
        4: begin min_v = 26;    ramp_v = 1;   target_v = 40;    cur_skip = 255; budget = 300; end
        5: begin min_v = 65500; ramp_v = 255; target_v = 65535; cur_skip = 2;   budget = 150; end
        default: begin
          min_v = 50; ramp_v = 3; target_v = 120; cur_skip = 0; budget = 150;
        end
      endcase
      if (s == 3) begin
        tx_idle_pct = 71;
        rx_idle_pct = 28;
      end else if (s == 5) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(CFG_MIN_RATE, CFG_DATA_W'(min_v));
      write_reg(CFG_RAMP_STEP, CFG_DATA_W'(ramp_v));
      write_reg(CFG_TARGET_RATE, CFG_DATA_W'(target_v));
      write_reg(CFG_SKIP_RELOAD, CFG_DATA_W'(cur_skip));
      jog_items = 0;
      while (jog_items < budget) run_jog(budget - jog_items);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0)
      $display("jog_step_rate_ramp_tb: done, clean");
    else
      $display("jog_step_rate_ramp_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/jsrr_pkg.sv
hw/rtl/jsrr_in_if.sv
hw/rtl/jsrr_out_if.sv
hw/rtl/jsrr_div.sv
hw/rtl/jsrr_datapath.sv
hw/rtl/jsrr_ctrl.sv
hw/rtl/jog_step_rate_ramp.sv
tb/jog_step_rate_ramp_checker.sv
tb/jog_step_rate_ramp_tb.sv
